// ===== hw/rtl/pip_pkg.sv =====
// shared types and constants for the point-in-polygon test block
// no dependencies; imported by every module of the block

package pip_pkg;

   // default sizing, used as the defaults of the top level parameters
   localparam int MAX_VERTICES_DEF = 256;
   localparam int COORD_WIDTH_DEF  = 32;

   // fixed widths of the request and response fields
   localparam int FIELD_WIDTH     = 32;
   localparam int COUNT_OUT_WIDTH = 9;

   // request kinds
   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_WALK,
      ST_DRAIN,
      ST_RESPOND
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;        // request taken this cycle, capture fields
      logic load_write;    // store vertex, update count, register load response
      logic walk;          // issue one vertex read of the edge walk
      logic finish_query;  // register query response
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic count_zero;    // store holds no vertex
      logic walk_last;     // current read is the last one of the walk
      logic pipe_busy;     // edge pipeline still holds work
   } status_type;

endpackage

// ===== hw/rtl/pip_ctrl.sv =====
// controller state machine of the point-in-polygon test block
// depends on pip_pkg for the state, command and status types

module pip_ctrl
   import pip_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       req_type,
   input  status_type status,
   output cmd_type    cmd,
   output logic       busy,
   output logic       rsp_valid
);

   state_type state_ff;
   state_type state_in;
   logic      ready;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE, ST_RESPOND: begin
            if (start) begin
               if (req_type == REQ_LOAD) begin
                  state_in = ST_LOAD;
               end else if (status.count_zero) begin
                  state_in = ST_DRAIN;
               end else begin
                  state_in = ST_WALK;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_LOAD: begin
            state_in = ST_RESPOND;
         end
         ST_WALK: begin
            if (status.walk_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ST_RESPOND;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs: a new request may be taken while the response strobe is shown
   always_comb begin
      ready            = (state_ff == ST_IDLE) || (state_ff == ST_RESPOND);
      busy             = !ready;
      rsp_valid        = (state_ff == ST_RESPOND);
      cmd.accept       = start && ready;
      cmd.load_write   = (state_ff == ST_LOAD);
      cmd.walk         = (state_ff == ST_WALK);
      cmd.finish_query = (state_ff == ST_DRAIN) && !status.pipe_busy;
   end

endmodule

// ===== hw/rtl/pip_datapath.sv =====
// datapath of the point-in-polygon test block: vertex store, edge walk,
// exact crossing test pipeline and response registers; depends on pip_pkg

module pip_datapath
   import pip_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF,
   parameter int COORD_WIDTH  = COORD_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  cmd_type                    cmd,
   input  logic                       req_new_polygon,
   input  logic [FIELD_WIDTH-1:0]     req_coord_x,
   input  logic [FIELD_WIDTH-1:0]     req_coord_y,
   output status_type                 status,
   output logic                       rsp_inside_res,
   output logic                       rsp_vertex_dropped,
   output logic [COUNT_OUT_WIDTH-1:0] rsp_vertex_count
);

   localparam int AW   = $clog2(MAX_VERTICES);
   localparam int CNTW = $clog2(MAX_VERTICES + 1);
   localparam int CW   = COORD_WIDTH;
   localparam int DW   = CW + 1;
   localparam int LW   = (CW + 1) / 2;
   localparam int HW   = CW - LW;
   localparam int PW   = 2 * CW;

   // magnitude of a coordinate difference, always below 2^CW
   function automatic logic [CW-1:0] diff_mag(input logic signed [DW-1:0] d);
      logic signed [DW-1:0] m;
      m = d[DW-1] ? -d : d;
      return m[CW-1:0];
   endfunction

   // request capture
   logic [2*FIELD_WIDTH-1:0] x_ext;
   logic [2*FIELD_WIDTH-1:0] y_ext;
   logic signed [CW-1:0]     px_ff;
   logic signed [CW-1:0]     py_ff;
   logic                     newp_ff;

   assign x_ext = {{FIELD_WIDTH{1'b0}}, req_coord_x};
   assign y_ext = {{FIELD_WIDTH{1'b0}}, req_coord_y};

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         px_ff   <= x_ext[CW-1:0];
         py_ff   <= y_ext[CW-1:0];
         newp_ff <= req_new_polygon;
      end
   end

   // vertex count and load decision
   logic [CNTW-1:0] count_ff;
   logic [CNTW-1:0] count_in;
   logic [CNTW-1:0] cnt_eff;
   logic            room;

   assign cnt_eff = newp_ff ? '0 : count_ff;
   assign room    = cnt_eff < CNTW'(MAX_VERTICES);

   always_comb begin
      count_in = count_ff;
      if (cmd.load_write) begin
         count_in = room ? cnt_eff + CNTW'(1) : cnt_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // edge walk addressing: prime with the last vertex, then 0 .. n-1
   logic [AW-1:0]   addr_ff;
   logic [CNTW-1:0] left_ff;
   logic            prime_ff;
   logic [CNTW-1:0] count_m1;

   assign count_m1 = count_ff - CNTW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff  <= '0;
         left_ff  <= '0;
         prime_ff <= 1'b0;
      end else if (cmd.accept) begin
         addr_ff  <= count_m1[AW-1:0];
         left_ff  <= count_ff;
         prime_ff <= 1'b1;
      end else if (cmd.walk) begin
         if (prime_ff) begin
            prime_ff <= 1'b0;
            addr_ff  <= '0;
         end else begin
            addr_ff <= addr_ff + AW'(1);
            left_ff <= left_ff - CNTW'(1);
         end
      end
   end

   // vertex store, one write and one registered read per cycle
   logic signed [CW-1:0] vx_mem [MAX_VERTICES];
   logic signed [CW-1:0] vy_mem [MAX_VERTICES];
   logic signed [CW-1:0] rd_x_ff;
   logic signed [CW-1:0] rd_y_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_write && room) begin
         vx_mem[cnt_eff[AW-1:0]] <= px_ff;
         vy_mem[cnt_eff[AW-1:0]] <= py_ff;
      end
      if (cmd.walk) begin
         rd_x_ff <= vx_mem[addr_ff];
         rd_y_ff <= vy_mem[addr_ff];
      end
   end

   // pipeline valid bits
   logic rd_v_ff;
   logic rd_edge_ff;
   logic s1_v_ff;
   logic s2_v_ff;
   logic s3_v_ff;
   logic s4_v_ff;

   // previous vertex (end j of the edge)
   logic signed [CW-1:0] xj_ff;
   logic signed [CW-1:0] yj_ff;

   always_ff @(posedge clock) begin
      if (rd_v_ff) begin
         xj_ff <= rd_x_ff;
         yj_ff <= rd_y_ff;
      end
   end

   // stage 1: differences and straddle test
   // operand pair 0: (X - xi) * dy, pair 1: (xj - xi) * (Y - yi)
   logic signed [DW-1:0] opa_in [2];
   logic signed [DW-1:0] opb_in [2];
   logic signed [DW-1:0] opa_ff [2];
   logic signed [DW-1:0] opb_ff [2];
   logic                 straddle;

   assign opa_in[0] = DW'(px_ff) - DW'(rd_x_ff);
   assign opb_in[0] = DW'(yj_ff) - DW'(rd_y_ff);
   assign opa_in[1] = DW'(xj_ff) - DW'(rd_x_ff);
   assign opb_in[1] = DW'(py_ff) - DW'(rd_y_ff);
   assign straddle  = (rd_y_ff > py_ff) != (yj_ff > py_ff);

   // stage 2..4 registers, one set per product
   logic [CW-1:0]    ma_ff [2];
   logic [CW-1:0]    mb_ff [2];
   logic             sg2_ff [2];
   logic             sg3_ff [2];
   logic             sg4_ff [2];
   logic [2*LW-1:0]  pp_ll_ff [2];
   logic [LW+HW-1:0] pp_lh_ff [2];
   logic [LW+HW-1:0] pp_hl_ff [2];
   logic [2*HW-1:0]  pp_hh_ff [2];
   logic [PW-1:0]    prod_ff [2];
   logic             dyneg2_ff;
   logic             dyneg3_ff;
   logic             dyneg4_ff;

   for (genvar k = 0; k < 2; k++) begin : g_prod
      logic [PW-1:0] sum_in;

      assign sum_in = PW'(pp_ll_ff[k])
                    + (PW'(pp_lh_ff[k]) << LW)
                    + (PW'(pp_hl_ff[k]) << LW)
                    + (PW'(pp_hh_ff[k]) << (2 * LW));

      always_ff @(posedge clock) begin
         // stage 1 register
         if (rd_v_ff) begin
            opa_ff[k] <= opa_in[k];
            opb_ff[k] <= opb_in[k];
         end
         // stage 2: magnitudes and product sign
         ma_ff[k]  <= diff_mag(opa_ff[k]);
         mb_ff[k]  <= diff_mag(opb_ff[k]);
         sg2_ff[k] <= opa_ff[k][DW-1] ^ opb_ff[k][DW-1];
         // stage 3: half-width partial products
         pp_ll_ff[k] <= ma_ff[k][LW-1:0]  * mb_ff[k][LW-1:0];
         pp_lh_ff[k] <= ma_ff[k][LW-1:0]  * mb_ff[k][CW-1:LW];
         pp_hl_ff[k] <= ma_ff[k][CW-1:LW] * mb_ff[k][LW-1:0];
         pp_hh_ff[k] <= ma_ff[k][CW-1:LW] * mb_ff[k][CW-1:LW];
         sg3_ff[k]   <= sg2_ff[k];
         // stage 4: full product magnitude
         prod_ff[k] <= sum_in;
         sg4_ff[k]  <= sg3_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      dyneg2_ff <= opb_ff[0][DW-1];
      dyneg3_ff <= dyneg2_ff;
      dyneg4_ff <= dyneg3_ff;
   end

   // stage 5: signed compare from magnitudes and signs
   logic mag_lt;
   logic mag_gt;
   logic both_zero;
   logic l_lt_r;
   logic r_lt_l;
   logic left;

   always_comb begin
      mag_lt    = prod_ff[0] < prod_ff[1];
      mag_gt    = prod_ff[1] < prod_ff[0];
      both_zero = (prod_ff[0] == '0) && (prod_ff[1] == '0);
      if (sg4_ff[0] == sg4_ff[1]) begin
         l_lt_r = sg4_ff[0] ? mag_gt : mag_lt;
         r_lt_l = sg4_ff[0] ? mag_lt : mag_gt;
      end else begin
         l_lt_r = sg4_ff[0] && !both_zero;
         r_lt_l = sg4_ff[1] && !both_zero;
      end
      left = dyneg4_ff ? r_lt_l : l_lt_r;
   end

   // valid chain and crossing parity
   logic inside_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff    <= 1'b0;
         rd_edge_ff <= 1'b0;
         s1_v_ff    <= 1'b0;
         s2_v_ff    <= 1'b0;
         s3_v_ff    <= 1'b0;
         s4_v_ff    <= 1'b0;
         inside_ff  <= 1'b0;
      end else begin
         rd_v_ff    <= cmd.walk;
         rd_edge_ff <= !prime_ff;
         s1_v_ff    <= rd_v_ff && rd_edge_ff && straddle;
         s2_v_ff    <= s1_v_ff;
         s3_v_ff    <= s2_v_ff;
         s4_v_ff    <= s3_v_ff;
         if (cmd.accept) begin
            inside_ff <= 1'b0;
         end else if (s4_v_ff && left) begin
            inside_ff <= !inside_ff;
         end
      end
   end

   // response registers
   logic                       rsp_inside_ff;
   logic                       rsp_dropped_ff;
   logic [COUNT_OUT_WIDTH-1:0] rsp_count_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_write) begin
         rsp_inside_ff  <= 1'b0;
         rsp_dropped_ff <= !room;
         rsp_count_ff   <= COUNT_OUT_WIDTH'(count_in);
      end else if (cmd.finish_query) begin
         rsp_inside_ff  <= inside_ff;
         rsp_dropped_ff <= 1'b0;
         rsp_count_ff   <= COUNT_OUT_WIDTH'(count_ff);
      end
   end

   assign rsp_inside_res     = rsp_inside_ff;
   assign rsp_vertex_dropped = rsp_dropped_ff;
   assign rsp_vertex_count   = rsp_count_ff;

   // status
   assign status.count_zero = (count_ff == '0);
   assign status.walk_last  = !prime_ff && (left_ff == CNTW'(1));
   assign status.pipe_busy  = rd_v_ff || s1_v_ff || s2_v_ff || s3_v_ff || s4_v_ff;

endmodule

// ===== hw/rtl/point_in_polygon_test.sv =====
// Even-odd point-in-polygon test on signed Q20.12 coordinates. A request is
// taken when start is high and busy is low; its response appears for exactly
// one cycle with rsp_valid and cannot be held off, and the next request may be
// taken in that same cycle. A load stores its vertex and registers its response in ST_LOAD.
// On a query to a store of n vertices, the single read port of the vertex store
// walks one vertex per cycle (n + 1 reads, the first one fetches the closing vertex),
// and a five-stage exact compare pipeline drains after the last read; the
// drain is shorter when the last edges do not straddle the query y. A query to an
// empty store skips the walk. Vertex store contents are undefined after reset;
// only the vertex count is cleared.
// depends on pip_pkg, pip_ctrl and pip_datapath

module point_in_polygon_test
   import pip_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF,
   parameter int COORD_WIDTH  = COORD_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic                       req_type,
   input  logic                       req_new_polygon,
   input  logic [FIELD_WIDTH-1:0]     req_coord_x,
   input  logic [FIELD_WIDTH-1:0]     req_coord_y,
   output logic                       rsp_valid,
   output logic                       rsp_inside_res,
   output logic                       rsp_vertex_dropped,
   output logic [COUNT_OUT_WIDTH-1:0] rsp_vertex_count
);

   cmd_type    cmd;
   status_type status;

   // sequencing
   pip_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_type  (req_type),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // store, walk and compare
   pip_datapath #(
      .MAX_VERTICES (MAX_VERTICES),
      .COORD_WIDTH  (COORD_WIDTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_new_polygon    (req_new_polygon),
      .req_coord_x        (req_coord_x),
      .req_coord_y        (req_coord_y),
      .status             (status),
      .rsp_inside_res     (rsp_inside_res),
      .rsp_vertex_dropped (rsp_vertex_dropped),
      .rsp_vertex_count   (rsp_vertex_count)
   );

endmodule

// ===== hw/rtl/pip_checker.sv =====
// port-level checks of the point-in-polygon test block, bound to the top level
// depends on pip_pkg and point_in_polygon_test

module pip_checker
   import pip_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       start,
   input logic                       busy,
   input logic                       rsp_valid,
   input logic                       rsp_inside_res,
   input logic                       rsp_vertex_dropped,
   input logic [COUNT_OUT_WIDTH-1:0] rsp_vertex_count
);

   // a taken request keeps the block busy in the following cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("request accepted but block not busy next cycle");

   // response strobe lasts a single cycle
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   // block is ready for the next request while a response is shown
   a_strobe_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("busy during response cycle");

   // a response is either a load or a query, never both flags
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_inside_res && rsp_vertex_dropped))
      else $error("inside and dropped flags both set");

   // response fields carry known values
   a_rsp_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown({rsp_inside_res, rsp_vertex_dropped, rsp_vertex_count}))
      else $error("unknown value on response fields");

endmodule

bind point_in_polygon_test pip_checker u_pip_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .rsp_valid          (rsp_valid),
   .rsp_inside_res     (rsp_inside_res),
   .rsp_vertex_dropped (rsp_vertex_dropped),
   .rsp_vertex_count   (rsp_vertex_count)
);

// ===== sim/tb.sv =====
// self-checking bench for point_in_polygon_test: directed and random requests with a
// built-in even-odd crossing predictor and a per-field response checker
// depends on pip_pkg and point_in_polygon_test

module tb;
   import pip_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int MAX_GAP        = 40;

   typedef struct {
      logic                       in_poly;
      logic                       dropped;
      logic [COUNT_OUT_WIDTH-1:0] count;
   } pip_answer_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   logic                       req_type = REQ_LOAD;
   logic                       req_new_polygon = 1'b0;
   logic [FIELD_WIDTH-1:0]     req_coord_x = '0;
   logic [FIELD_WIDTH-1:0]     req_coord_y = '0;
   logic                       rsp_valid;
   logic                       rsp_inside_res;
   logic                       rsp_vertex_dropped;
   logic [COUNT_OUT_WIDTH-1:0] rsp_vertex_count;

   // predictor copy of the vertex store
   logic signed [FIELD_WIDTH-1:0] poly_x [MAX_VERTICES_DEF];
   logic signed [FIELD_WIDTH-1:0] poly_y [MAX_VERTICES_DEF];
   int unsigned                   poly_count = 0;

   pip_answer_type pending_answers [$];
   int             error_count = 0;
   int             send_idle_pct = 0;
   int             requests_sent = 0;
   int             quiet_cycles = 0;

   point_in_polygon_test dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_type           (req_type),
      .req_new_polygon    (req_new_polygon),
      .req_coord_x        (req_coord_x),
      .req_coord_y        (req_coord_y),
      .rsp_valid          (rsp_valid),
      .rsp_inside_res     (rsp_inside_res),
      .rsp_vertex_dropped (rsp_vertex_dropped),
      .rsp_vertex_count   (rsp_vertex_count)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // update the vertex store copy and work out the response of one request
   function automatic pip_answer_type predict_answer(input logic kind, input logic fresh,
                                                     input logic signed [FIELD_WIDTH-1:0] px,
                                                     input logic signed [FIELD_WIDTH-1:0] py);
      pip_answer_type  ans;
      int unsigned     i;
      int unsigned     j;
      logic            odd;
      logic            left;
      logic signed [67:0] dy;
      logic signed [67:0] lhs;
      logic signed [67:0] rhs;
      ans.in_poly = 1'b0;
      ans.dropped = 1'b0;
      odd = 1'b0;
      if (kind == REQ_LOAD) begin
         if (fresh) poly_count = 0;
         if (poly_count < MAX_VERTICES_DEF) begin
            poly_x[poly_count] = px;
            poly_y[poly_count] = py;
            poly_count++;
         end else begin
            ans.dropped = 1'b1;
         end
      end else if (poly_count != 0) begin
         // walk edges (i, i-1), closing edge first
         j = poly_count - 1;
         for (i = 0; i < poly_count; i++) begin
            if ((poly_y[i] > py) != (poly_y[j] > py)) begin
               dy   = poly_y[j] - poly_y[i];
               lhs  = (px - poly_x[i]) * dy;
               rhs  = (poly_x[j] - poly_x[i]) * (py - poly_y[i]);
               left = (dy > 0) ? (lhs < rhs) : (rhs < lhs);
               if (left) odd = ~odd;
            end
            j = i;
         end
         ans.in_poly = odd;
      end
      ans.count = poly_count[COUNT_OUT_WIDTH-1:0];
      return ans;
   endfunction

   // coordinate within span of a center
   function automatic logic [FIELD_WIDTH-1:0] jitter_coord(input longint center,
                                                          input longint span);
      longint off;
      off = longint'($urandom_range(int'(2 * span))) - span;
      return FIELD_WIDTH'(center + off);
   endfunction

   // drive one request, wait for acceptance, record its expected response
   task automatic send_request(input logic kind, input logic fresh,
                               input logic [FIELD_WIDTH-1:0] px,
                               input logic [FIELD_WIDTH-1:0] py);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start           <= 1'b1;
      req_type        <= kind;
      req_new_polygon <= fresh;
      req_coord_x     <= px;
      req_coord_y     <= py;
      do @(posedge clock); while (busy);
      pending_answers.insert(pending_answers.size(), predict_answer(kind, fresh, px, py));
      requests_sent++;
   endtask

   // queries before any vertex, and a load into the empty store
   task automatic test_empty_store();
      send_request(REQ_QUERY, 1'b0, 32'h0000_0000, 32'h0000_0000);
      send_request(REQ_QUERY, 1'b1, 32'h8000_0000, 32'h7fff_ffff);
      send_request(REQ_LOAD, 1'b1, 32'h0000_1000, 32'h0000_2000);
      send_request(REQ_LOAD, 1'b1, 32'h0000_0000, 32'h0000_0000);
   endtask

   // one and two vertex stores, where edges are degenerate or walked twice
   task automatic test_degenerate_polygons();
      send_request(REQ_QUERY, 1'b0, 32'hffff_f000, 32'h0000_0000);
      send_request(REQ_LOAD, 1'b0, 32'h0000_1000, 32'h0000_2000);
      send_request(REQ_QUERY, 1'b0, 32'h0000_0000, 32'h0000_1000);
      send_request(REQ_QUERY, 1'b0, 32'h0000_2000, 32'h0000_1000);
   endtask

   // square, clockwise triangle and a polygon at the coordinate extremes
   task automatic test_regular_shapes();
      send_request(REQ_LOAD, 1'b1, 32'hffff_f000, 32'hffff_f000);
      send_request(REQ_LOAD, 1'b0, 32'h0000_1000, 32'hffff_f000);
      send_request(REQ_LOAD, 1'b0, 32'h0000_1000, 32'h0000_1000);
      send_request(REQ_LOAD, 1'b0, 32'hffff_f000, 32'h0000_1000);
      send_request(REQ_QUERY, 1'b0, 32'h0000_0000, 32'h0000_0000);
      send_request(REQ_QUERY, 1'b0, 32'h0000_2000, 32'h0000_0000);
      send_request(REQ_QUERY, 1'b0, 32'h0000_0000, 32'h0000_1000);
      send_request(REQ_QUERY, 1'b0, 32'hffff_f000, 32'h0000_0800);
      // clockwise triangle, so dy runs negative on some edges
      send_request(REQ_LOAD, 1'b1, 32'h0000_0000, 32'h0000_4000);
      send_request(REQ_LOAD, 1'b0, 32'h0000_4000, 32'hffff_c000);
      send_request(REQ_LOAD, 1'b0, 32'hffff_c000, 32'hffff_c000);
      send_request(REQ_QUERY, 1'b0, 32'h0000_0100, 32'h0000_0000);
      // extremes of the coordinate range
      send_request(REQ_LOAD, 1'b1, 32'h8000_0000, 32'h8000_0000);
      send_request(REQ_LOAD, 1'b0, 32'h7fff_ffff, 32'h8000_0000);
      send_request(REQ_LOAD, 1'b0, 32'h7fff_ffff, 32'h7fff_ffff);
      send_request(REQ_LOAD, 1'b0, 32'h8000_0000, 32'h7fff_ffff);
      send_request(REQ_QUERY, 1'b0, 32'h0000_0000, 32'h0000_0000);
      send_request(REQ_QUERY, 1'b0, 32'h8000_0000, 32'hffff_ffff);
      send_request(REQ_QUERY, 1'b0, 32'h7fff_ffff, 32'h0000_0001);
   endtask

   // fill the store, overflow it, walk it whole, then restart it while full
   task automatic test_full_store();
      int k;
      for (k = 0; k < MAX_VERTICES_DEF; k++)
         send_request(REQ_LOAD, k == 0, jitter_coord(0, 1 << 20), jitter_coord(0, 1 << 20));
      send_request(REQ_LOAD, 1'b0, 32'h7fff_ffff, 32'h8000_0000);
      send_request(REQ_QUERY, 1'b0, 32'h0000_0000, 32'h0000_0000);
      send_request(REQ_QUERY, 1'b1, jitter_coord(0, 1 << 20), jitter_coord(0, 1 << 20));
      send_request(REQ_LOAD, 1'b1, 32'h0000_0000, 32'h0000_0000);
   endtask

   // random polygons with queries around them, plus noise and broken sequences
   task automatic test_random_polygons(input int item_total);
      int     sel;
      int     verts;
      int     queries;
      int     k;
      longint span;
      longint cx;
      longint cy;
      logic [FIELD_WIDTH-1:0] qy;
      item_total += requests_sent;
      while (requests_sent < item_total) begin
         sel = $urandom_range(99);
         if (sel < 5) begin
            // noise: any field value at all
            send_request(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom, $urandom);
         end else begin
            sel = $urandom_range(199);
            if (sel < 10)       verts = $urandom_range(1, 2);
            else if (sel < 170) verts = $urandom_range(3, 12);
            else if (sel < 198) verts = $urandom_range(13, 60);
            else                verts = $urandom_range(240, 260);
            span = longint'(1) << (6 * $urandom_range(1, 4) + $urandom_range(0, 5));
            cx = longint'($signed(jitter_coord(0, 1 << 29)));
            cy = longint'($signed(jitter_coord(0, 1 << 29)));
            for (k = 0; k < verts; k++) begin
               // occasionally a query cuts into the load sequence
               if (k > 0 && $urandom_range(99) < 3)
                  send_request(REQ_QUERY, 1'b0, jitter_coord(cx, span), jitter_coord(cy, span));
               send_request(REQ_LOAD, k == 0, jitter_coord(cx, span), jitter_coord(cy, span));
            end
            queries = $urandom_range(2, 8);
            for (k = 0; k < queries; k++) begin
               if (poly_count != 0 && $urandom_range(99) < 20)
                  qy = poly_y[$urandom_range(poly_count - 1)];
               else
                  qy = jitter_coord(cy, span + span / 4);
               send_request(REQ_QUERY, 1'($urandom_range(1)),
                            jitter_coord(cx, span + span / 4), qy);
            end
         end
      end
   endtask

   // compare each response with the oldest expectation
   always @(posedge clock) begin
      pip_answer_type exp_ans;
      if (!reset && rsp_valid) begin
         if (pending_answers.size() == 0) begin
            $display("%0t unexpected response: inside %0b dropped %0b count %0d", $time,
                     rsp_inside_res, rsp_vertex_dropped, rsp_vertex_count);
            error_count++;
         end else begin
            exp_ans = pending_answers.pop_front();
            if (rsp_inside_res !== exp_ans.in_poly) begin
               $display("%0t inside_res: expected %0b actual %0b", $time,
                        exp_ans.in_poly, rsp_inside_res);
               error_count++;
            end
            if (rsp_vertex_dropped !== exp_ans.dropped) begin
               $display("%0t vertex_dropped: expected %0b actual %0b", $time,
                        exp_ans.dropped, rsp_vertex_dropped);
               error_count++;
            end
            if (rsp_vertex_count !== exp_ans.count) begin
               $display("%0t vertex_count: expected %0d actual %0d", $time,
                        exp_ans.count, rsp_vertex_count);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles with neither a request nor a response taken
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_empty_store();
      test_degenerate_polygons();
      test_regular_shapes();
      test_full_store();
      send_idle_pct = 38;
      test_random_polygons(600);
      send_idle_pct = 68;
      test_random_polygons(600);
      send_idle_pct = 0;
      test_random_polygons(500);
      @(posedge clock);
      start <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      // catch any stray response after the last one
      repeat (300) @(posedge clock);
      if (error_count == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/pip_pkg.sv
hw/rtl/pip_ctrl.sv
hw/rtl/pip_datapath.sv
hw/rtl/point_in_polygon_test.sv
hw/rtl/pip_checker.sv
sim/tb.sv
